>>> rtl/tmavg_pkg.sv
// shared constants and types for the three-axis masked moving average
package tmavg_pkg;

   localparam int WINDOW_SIZE = 16;
   localparam int SAMPLE_W    = 16;
   localparam int AXES        = 3;
   localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_SIZE);
   localparam int STEP_W      = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = 1;
   localparam int FIFO_CNT_W  = 2;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_MARKER = 1'b0;

   localparam logic signed [SAMPLE_W-1:0] MARKER_RESET = -16'sd32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [CNT_W-1:0]           count_type;

   typedef struct packed {
      sample_type        z;
      sample_type        y;
      sample_type        x;
      logic [AXES-1:0]   vbits;
   } item_type;

   typedef struct packed {
      sample_type z;
      sample_type y;
      sample_type x;
   } entry_type;

endpackage

>>> rtl/tmavg_if.sv
// channel interfaces for samples and averages
interface tmavg_req_if import tmavg_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_x;
   sample_type sample_y;
   sample_type sample_z;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                   output ready);
endinterface

interface tmavg_rsp_if import tmavg_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type avg_x;
   sample_type avg_y;
   sample_type avg_z;
   logic       x_empty;
   logic       y_empty;
   logic       z_empty;

   modport source (output valid, output avg_x, output avg_y, output avg_z,
                   output x_empty, output y_empty, output z_empty, input ready);
   modport sink   (input valid, input avg_x, input avg_y, input avg_z,
                   input x_empty, input y_empty, input z_empty, output ready);
endinterface

>>> rtl/tmavg_front.sv
// input side: marker classification and a two-entry queue to the back end
module tmavg_front import tmavg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tmavg_req_if.sink  req,
   input  sample_type marker,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type                fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    push;
   logic                    pop;
   item_type                new_item;

   assign req.ready  = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign push       = req.valid && req.ready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = fifo_mem[rd_ptr_ff];

   always_comb begin
      new_item.x     = req.sample_x;
      new_item.y     = req.sample_y;
      new_item.z     = req.sample_z;
      new_item.vbits = {req.sample_z != marker, req.sample_y != marker,
                        req.sample_x != marker};
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/tmavg_div.sv
// restoring serial divider, one quotient bit per cycle, truncates toward zero
module tmavg_div import tmavg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  sum_type    dividend,
   input  count_type  divisor,
   output logic       done,
   output sample_type quotient
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   count_type           div_ff, div_in;
   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;
   logic [SUM_W-1:0]    signed_quo;

   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign diff       = trial - {1'b0, div_ff};
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[SAMPLE_W-1:0];
   assign done       = done_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[SUM_W-1];
         // magnitude; the most negative sum still fits as unsigned
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

>>> rtl/tmavg_back.sv
// back end: ring window, running sums and counts, dividers, result register
module tmavg_back import tmavg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   tmavg_rsp_if.source rsp
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;

   entry_type         win_mem [WINDOW_SIZE];
   entry_type         rd_data_ff;
   logic [AXES-1:0]   valid_ff [WINDOW_SIZE];
   logic [AXES-1:0]   valid_in [WINDOW_SIZE];
   logic [IDX_W-1:0]  pos_ff, pos_in;
   sum_type           sums_ff [AXES];
   sum_type           sums_in [AXES];
   count_type         counts_ff [AXES];
   count_type         counts_in [AXES];
   logic [2:0]        state_ff, state_in;
   item_type          cur_ff, cur_in;
   logic              wr_en;
   logic              div_start;
   logic [AXES-1:0]   div_done;
   sample_type        quo [AXES];
   sample_type        old_s [AXES];
   sample_type        new_s [AXES];
   logic              out_free;
   logic              out_load;

   logic              out_valid_ff, out_valid_in;
   sample_type        avg_ff [AXES];
   logic [AXES-1:0]   empty_ff;

   assign old_s[0] = rd_data_ff.x;
   assign old_s[1] = rd_data_ff.y;
   assign old_s[2] = rd_data_ff.z;
   assign new_s[0] = cur_ff.x;
   assign new_s[1] = cur_ff.y;
   assign new_s[2] = cur_ff.z;

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      item_pop  = 1'b0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      valid_in  = valid_ff;
      sums_in   = sums_ff;
      counts_in = counts_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // drop the overwritten entry from the totals, add the new one
            wr_en = 1'b1;
            for (int a = 0; a < AXES; a++) begin
               sums_in[a] = sums_ff[a]
                          - (valid_ff[pos_ff][a] ? SUM_W'(old_s[a]) : sum_type'(0))
                          + (cur_ff.vbits[a] ? SUM_W'(new_s[a]) : sum_type'(0));
               counts_in[a] = counts_ff[a]
                            - count_type'(valid_ff[pos_ff][a])
                            + count_type'(cur_ff.vbits[a]);
            end
            valid_in[pos_ff] = cur_ff.vbits;
            pos_in   = (pos_ff == IDX_W'(WINDOW_SIZE - 1)) ? '0 : pos_ff + 1'b1;
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (&div_done) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            valid_ff[i] <= '0;
         end
         for (int a = 0; a < AXES; a++) begin
            sums_ff[a]   <= '0;
            counts_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
         sums_ff      <= sums_in;
         counts_ff    <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (out_load) begin
         for (int a = 0; a < AXES; a++) begin
            avg_ff[a]   <= (counts_ff[a] == '0) ? sample_type'(0) : quo[a];
            empty_ff[a] <= (counts_ff[a] == '0);
         end
      end
   end

   // window storage, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[pos_ff] <= '{z: cur_ff.z, y: cur_ff.y, x: cur_ff.x};
      end
      rd_data_ff <= win_mem[pos_ff];
   end

   for (genvar a = 0; a < AXES; a++) begin : g_div
      tmavg_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (sums_ff[a]),
         .divisor  (counts_ff[a]),
         .done     (div_done[a]),
         .quotient (quo[a])
      );
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.avg_x   = avg_ff[0];
   assign rsp.avg_y   = avg_ff[1];
   assign rsp.avg_z   = avg_ff[2];
   assign rsp.x_empty = empty_ff[0];
   assign rsp.y_empty = empty_ff[1];
   assign rsp.z_empty = empty_ff[2];

endmodule

>>> rtl/three_axis_masked_moving_average_unit.sv
// top level: configuration register, front end and back end
// Each sample transaction yields one average transaction: the sample replaces the
// oldest of 16 window entries and each axis gives the mean, truncated toward zero, of
// its entries that did not equal the marker register when written (0 and the empty
// flag when none). The back end takes an item from the queue while the old window
// entry is read, updates the running sums, starts the dividers, lets the three serial
// dividers run in parallel, sees them finish and, once the result register is free,
// loads it. A two-entry queue takes samples while the back end works, and the result
// register holds a finished average while the next sample is already in process. The
// marker register (byte address 0) applies to samples accepted after the write; the
// user must see that it is written only while idle, which the block does not enforce.
module three_axis_masked_moving_average_unit import tmavg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tmavg_req_if.sink             req,
   tmavg_rsp_if.source           rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   sample_type marker_ff, marker_in;
   logic       csr_write;
   logic       item_valid;
   item_type   item;
   logic       item_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      marker_in = marker_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MARKER)) begin
         marker_in = csr_pwdata[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else begin
         marker_ff <= marker_in;
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MARKER)
                     ? CSR_DATA_W'(marker_ff) : '0;

   tmavg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .marker     (marker_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   tmavg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp        (rsp)
   );

endmodule
